/* design/diff_drive_incremental_pid_assert.svh */
// assertion macros used by the top design file
// signals clk and arst_n must be in scope where a macro is used
`ifndef DIFF_DRIVE_INCREMENTAL_PID_ASSERT_SVH
`define DIFF_DRIVE_INCREMENTAL_PID_ASSERT_SVH

// same-cycle implication
`define DDPID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDPID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ddpid_pkg.sv */
package ddpid_pkg;

	localparam int unsigned PWM_MAX_DEF = 255;

	localparam int SPEED_W    = 16;
	localparam int WB_W       = 16;
	localparam int GAIN_W     = 32;
	localparam int SP_W       = 18;
	localparam int SP_CMD_W   = 25;
	localparam int HALF_SHIFT = 9;
	localparam int FRAC_SHIFT = 24;
	localparam int PWM_W      = 9;
	localparam int BRIDGE_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int SP_HI = 2 ** (SP_W - 1) - 1;
	localparam int SP_LO = -(2 ** (SP_W - 1));

	localparam logic [CFG_IDX_W-1:0] REG_GAIN0_RIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN1_RIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN2_RIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN0_LEFT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN1_LEFT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN2_LEFT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE  = 3'd6;

	localparam logic [BRIDGE_W-1:0] BRIDGE_POS   = 2'd1;
	localparam logic [BRIDGE_W-1:0] BRIDGE_NEG   = 2'd2;
	localparam logic [BRIDGE_W-1:0] BRIDGE_BRAKE = 2'd3;

	typedef enum logic [2:0] {
		MODE_STOP = 3'b001,
		MODE_POS  = 3'b010,
		MODE_NEG  = 3'b100
	} mode_t;

	typedef struct packed {
		logic step;
		logic tick;
	} wheel_ctrl_t;

endpackage

/* design/ddpid_item_if.sv */
interface ddpid_item_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     op;
	logic signed [ddpid_pkg::SPEED_W-1:0]     lin_speed;
	logic signed [ddpid_pkg::SPEED_W-1:0]     ang_speed;
	logic signed [ddpid_pkg::SPEED_W-1:0]     meas_right;
	logic signed [ddpid_pkg::SPEED_W-1:0]     meas_left;

	modport source (
		output valid, op, lin_speed, ang_speed, meas_right, meas_left,
		input  ready
	);
	modport sink (
		input  valid, op, lin_speed, ang_speed, meas_right, meas_left,
		output ready
	);
endinterface

/* design/ddpid_result_if.sv */
interface ddpid_result_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [ddpid_pkg::PWM_W-1:0]       pwm_right;
	logic signed [ddpid_pkg::PWM_W-1:0]       pwm_left;
	logic [ddpid_pkg::BRIDGE_W-1:0]           bridge_right;
	logic [ddpid_pkg::BRIDGE_W-1:0]           bridge_left;

	modport source (
		output valid, pwm_right, pwm_left, bridge_right, bridge_left,
		input  ready
	);
	modport sink (
		input  valid, pwm_right, pwm_left, bridge_right, bridge_left,
		output ready
	);
endinterface

/* design/diff_drive_incremental_pid.sv */
// channel   dir  payload                                          role
// item      in   op, lin_speed, ang_speed, meas_right, meas_left  command or control tick
// result    out  pwm_right, pwm_left, bridge_right, bridge_left   duties and bridge bits
//
// one beat per cycle sustained while result.ready stays high
// stage 1 is the input register, the wheel math runs into the result register
// valid flags, config and wheel state are cleared by arst_n: stop mode, zero setpoints, errors and duties
// a stalled result holds stage 1; item.ready drops only when both stages are full

`include "diff_drive_incremental_pid_assert.svh"

module diff_drive_incremental_pid #(
	parameter int unsigned PWM_MAX = ddpid_pkg::PWM_MAX_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [ddpid_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ddpid_pkg::CFG_DATA_W-1:0]       cfg_data,
	ddpid_item_if.sink                             item,
	ddpid_result_if.source                         result
);

	localparam int SW    = ddpid_pkg::SPEED_W;
	localparam int WB_W  = ddpid_pkg::WB_W;
	localparam int GW    = ddpid_pkg::GAIN_W;
	localparam int MUL_W = SW + WB_W + 1;
	localparam int CMD_W = ddpid_pkg::SP_CMD_W;
	localparam logic signed [MUL_W-1:0] HALF_BIAS = MUL_W'(2 ** ddpid_pkg::HALF_SHIFT - 1);

	// configuration
	logic signed [GW-1:0] gain0_right_q, gain1_right_q, gain2_right_q;
	logic signed [GW-1:0] gain0_left_q, gain1_left_q, gain2_left_q;
	logic [WB_W-1:0]      wheel_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain0_right_q <= '0;
			gain1_right_q <= '0;
			gain2_right_q <= '0;
			gain0_left_q  <= '0;
			gain1_left_q  <= '0;
			gain2_left_q  <= '0;
			wheel_base_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ddpid_pkg::REG_GAIN0_RIGHT: gain0_right_q <= GW'(cfg_data);
				ddpid_pkg::REG_GAIN1_RIGHT: gain1_right_q <= GW'(cfg_data);
				ddpid_pkg::REG_GAIN2_RIGHT: gain2_right_q <= GW'(cfg_data);
				ddpid_pkg::REG_GAIN0_LEFT:  gain0_left_q  <= GW'(cfg_data);
				ddpid_pkg::REG_GAIN1_LEFT:  gain1_left_q  <= GW'(cfg_data);
				ddpid_pkg::REG_GAIN2_LEFT:  gain2_left_q  <= GW'(cfg_data);
				ddpid_pkg::REG_WHEEL_BASE:  wheel_base_q  <= WB_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// handshake
	logic valid_s1;
	logic res_valid_q;
	logic advance;

	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready   = !valid_s1 || advance;
	assign result.valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	// stage 1 input register
	logic                 op_s1;
	logic signed [SW-1:0] lin_s1, ang_s1, meas_right_s1, meas_left_s1;

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1         <= item.op;
			lin_s1        <= item.lin_speed;
			ang_s1        <= item.ang_speed;
			meas_right_s1 <= item.meas_right;
			meas_left_s1  <= item.meas_left;
		end
	end

	// half track term, rounded toward zero
	logic signed [MUL_W-1:0] track_prod;
	logic signed [MUL_W-1:0] track_adj;
	logic signed [CMD_W-1:0] half;
	logic signed [CMD_W-1:0] sp_right_cmd, sp_left_cmd;

	assign track_prod   = MUL_W'(ang_s1) * MUL_W'(signed'({1'b0, wheel_base_q}));
	assign track_adj    = track_prod + (track_prod[MUL_W-1] ? HALF_BIAS : '0);
	assign half         = CMD_W'(track_adj >>> ddpid_pkg::HALF_SHIFT);
	assign sp_right_cmd = CMD_W'(lin_s1) + half;
	assign sp_left_cmd  = CMD_W'(lin_s1) - half;

	ddpid_pkg::wheel_ctrl_t ctrl;
	assign ctrl.step = advance;
	assign ctrl.tick = op_s1;

	logic signed [ddpid_pkg::PWM_W-1:0] pwm_right_nx, pwm_left_nx;
	logic [ddpid_pkg::BRIDGE_W-1:0]     bridge_right_nx, bridge_left_nx;

	ddpid_wheel #(.PWM_MAX(PWM_MAX)) u_wheel_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sp_cmd    (sp_right_cmd),
		.meas      (meas_right_s1),
		.gain0     (gain0_right_q),
		.gain1     (gain1_right_q),
		.gain2     (gain2_right_q),
		.pwm_nx    (pwm_right_nx),
		.bridge_nx (bridge_right_nx)
	);

	ddpid_wheel #(.PWM_MAX(PWM_MAX)) u_wheel_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sp_cmd    (sp_left_cmd),
		.meas      (meas_left_s1),
		.gain0     (gain0_left_q),
		.gain1     (gain1_left_q),
		.gain2     (gain2_left_q),
		.pwm_nx    (pwm_left_nx),
		.bridge_nx (bridge_left_nx)
	);

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			result.pwm_right    <= pwm_right_nx;
			result.pwm_left     <= pwm_left_nx;
			result.bridge_right <= bridge_right_nx;
			result.bridge_left  <= bridge_left_nx;
		end
	end

	logic res_brake_r, res_brake_l, both_full;
	assign res_brake_r = result.valid && result.bridge_right == ddpid_pkg::BRIDGE_BRAKE;
	assign res_brake_l = result.valid && result.bridge_left == ddpid_pkg::BRIDGE_BRAKE;
	assign both_full   = valid_s1 && result.valid && !result.ready;

	`DDPID_ASSERT_NOW(a_brake_r, res_brake_r, result.pwm_right == '0, "right brake with duty")
	`DDPID_ASSERT_NOW(a_brake_l, res_brake_l, result.pwm_left == '0, "left brake with duty")
	`DDPID_ASSERT_NOW(a_full_stall, both_full, !item.ready, "item taken while full")
	`DDPID_ASSERT_NEXT(a_beat_lands, item.valid && item.ready, valid_s1, "beat lost at stage 1")

endmodule

/* design/ddpid_wheel.sv */
module ddpid_wheel #(
	parameter int unsigned PWM_MAX = ddpid_pkg::PWM_MAX_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  ddpid_pkg::wheel_ctrl_t                  ctrl,
	input  logic signed [ddpid_pkg::SP_CMD_W-1:0]   sp_cmd,
	input  logic signed [ddpid_pkg::SPEED_W-1:0]    meas,
	input  logic signed [ddpid_pkg::GAIN_W-1:0]     gain0,
	input  logic signed [ddpid_pkg::GAIN_W-1:0]     gain1,
	input  logic signed [ddpid_pkg::GAIN_W-1:0]     gain2,
	output logic signed [ddpid_pkg::PWM_W-1:0]      pwm_nx,
	output logic [ddpid_pkg::BRIDGE_W-1:0]          bridge_nx
);

	localparam int SP_W   = ddpid_pkg::SP_W;
	localparam int CMD_W  = ddpid_pkg::SP_CMD_W;
	localparam int DUTY_W = $clog2(PWM_MAX + 1) + 1;
	localparam int PROD_W = ddpid_pkg::GAIN_W + SP_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int INC_W  = SUM_W - ddpid_pkg::FRAC_SHIFT;
	localparam int D_W    = ((INC_W > DUTY_W) ? INC_W : DUTY_W) + 1;
	localparam logic signed [D_W-1:0]   D_MAX     = D_W'(PWM_MAX);
	localparam logic signed [D_W-1:0]   D_ZERO    = '0;
	localparam logic signed [SP_W-1:0]  SP_ZERO   = '0;
	localparam logic signed [SUM_W-1:0] FRAC_BIAS = SUM_W'(2 ** ddpid_pkg::FRAC_SHIFT - 1);

	function automatic logic signed [SP_W-1:0] sat_sp(input logic signed [CMD_W-1:0] x);
		if (x > CMD_W'(ddpid_pkg::SP_HI))
			return SP_W'(ddpid_pkg::SP_HI);
		else if (x < CMD_W'(ddpid_pkg::SP_LO))
			return SP_W'(ddpid_pkg::SP_LO);
		else
			return SP_W'(x);
	endfunction

	logic signed [SP_W-1:0]   sp_q;
	logic signed [SP_W-1:0]   err0_q;
	logic signed [SP_W-1:0]   err1_q;
	logic signed [DUTY_W-1:0] duty_q;
	ddpid_pkg::mode_t         mode_q;

	logic signed [SP_W-1:0]   sp_sat;
	logic signed [CMD_W-1:0]  err_raw;
	logic signed [SP_W-1:0]   e0;
	logic signed [PROD_W-1:0] p0, p1, p2;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_adj;
	logic signed [INC_W-1:0]  inc;
	logic signed [D_W-1:0]    d_raw;
	logic signed [D_W-1:0]    d_clamp;
	logic signed [DUTY_W-1:0] duty_new;
	ddpid_pkg::mode_t         mode_cmd;
	ddpid_pkg::mode_t         mode_new;

	// command path
	assign sp_sat = sat_sp(sp_cmd);

	always_comb begin
		if (sp_sat > SP_ZERO)
			mode_cmd = ddpid_pkg::MODE_POS;
		else if (sp_sat < SP_ZERO)
			mode_cmd = ddpid_pkg::MODE_NEG;
		else
			mode_cmd = ddpid_pkg::MODE_STOP;
	end

	// tick path
	assign err_raw = CMD_W'(sp_q) - CMD_W'(meas);
	assign e0      = sat_sp(err_raw);
	assign p0      = PROD_W'(gain0) * PROD_W'(e0);
	assign p1      = PROD_W'(gain1) * PROD_W'(err0_q);
	assign p2      = PROD_W'(gain2) * PROD_W'(err1_q);
	assign sum     = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
	// round toward zero before the shift
	assign sum_adj = sum + (sum[SUM_W-1] ? FRAC_BIAS : '0);
	assign inc     = INC_W'(sum_adj >>> ddpid_pkg::FRAC_SHIFT);
	assign d_raw   = D_W'(duty_q) + D_W'(inc);

	always_comb begin
		unique case (mode_q)
			ddpid_pkg::MODE_POS: begin
				if (d_raw > D_MAX)
					d_clamp = D_MAX;
				else if (d_raw < D_ZERO)
					d_clamp = D_ZERO;
				else
					d_clamp = d_raw;
			end
			ddpid_pkg::MODE_NEG: begin
				if (d_raw > D_ZERO)
					d_clamp = D_ZERO;
				else if (d_raw < -D_MAX)
					d_clamp = -D_MAX;
				else
					d_clamp = d_raw;
			end
			default: d_clamp = D_ZERO;
		endcase
	end

	always_comb begin
		if (ctrl.tick) begin
			duty_new = DUTY_W'(d_clamp);
			mode_new = mode_q;
		end else begin
			duty_new = (sp_sat == '0) ? '0 : duty_q;
			mode_new = mode_cmd;
		end
	end

	assign pwm_nx = ddpid_pkg::PWM_W'(duty_new);

	always_comb begin
		unique case (mode_new)
			ddpid_pkg::MODE_POS: bridge_nx = ddpid_pkg::BRIDGE_POS;
			ddpid_pkg::MODE_NEG: bridge_nx = ddpid_pkg::BRIDGE_NEG;
			default:             bridge_nx = ddpid_pkg::BRIDGE_BRAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			err0_q <= '0;
			err1_q <= '0;
			duty_q <= '0;
			mode_q <= ddpid_pkg::MODE_STOP;
		end else if (ctrl.step) begin
			duty_q <= duty_new;
			mode_q <= mode_new;
			if (ctrl.tick) begin
				err0_q <= e0;
				err1_q <= err0_q;
			end else begin
				sp_q <= sp_sat;
			end
		end
	end

endmodule

/* dv/tb_diff_drive_incremental_pid.sv */
`timescale 1ns / 100ps

module tb_diff_drive_incremental_pid;

	localparam int SPEED_W = ddpid_pkg::SPEED_W;
	localparam int PWM_W = ddpid_pkg::PWM_W;
	localparam int BRIDGE_W = ddpid_pkg::BRIDGE_W;
	localparam int CFG_IDX_W = ddpid_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = ddpid_pkg::CFG_DATA_W;
	localparam int WB_W = ddpid_pkg::WB_W;
	localparam longint PWM_LIMIT = longint'(ddpid_pkg::PWM_MAX_DEF);
	localparam int SETTLE = 4;
	localparam int unsigned LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 165;
	localparam logic OP_CMD = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int WHEEL_R = 0;
	localparam int WHEEL_L = 1;

	typedef struct {
		logic [PWM_W-1:0]    pwm_r;
		logic [PWM_W-1:0]    pwm_l;
		logic [BRIDGE_W-1:0] br_r;
		logic [BRIDGE_W-1:0] br_l;
	} drive_out_t;

	class duty_checker;
		longint           gain [2][3];
		longint           setpoint [2];
		ddpid_pkg::mode_t mode [2];
		longint           err [2][2];
		longint           duty [2];
		longint           base;
		drive_out_t       pending_duty [$];
		int               errors;

		function new();
			foreach (setpoint[w]) begin
				setpoint[w] = 0;
				mode[w] = ddpid_pkg::MODE_STOP;
				duty[w] = 0;
				err[w][0] = 0;
				err[w][1] = 0;
				foreach (gain[w][k]) gain[w][k] = 0;
			end
			base = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx < ddpid_pkg::REG_GAIN0_LEFT) begin
				gain[WHEEL_R][idx] = longint'($signed(data));
			end else if (idx < ddpid_pkg::REG_WHEEL_BASE) begin
				gain[WHEEL_L][idx - ddpid_pkg::REG_GAIN0_LEFT] = longint'($signed(data));
			end else if (idx == ddpid_pkg::REG_WHEEL_BASE) begin
				base = longint'(data[WB_W-1:0]);
			end
		endfunction

		function longint sat18(longint x);
			if (x > ddpid_pkg::SP_HI) return ddpid_pkg::SP_HI;
			if (x < ddpid_pkg::SP_LO) return ddpid_pkg::SP_LO;
			return x;
		endfunction

		function void set_wheel(int w, longint sp);
			setpoint[w] = sat18(sp);
			if (setpoint[w] > 0) begin
				mode[w] = ddpid_pkg::MODE_POS;
			end else if (setpoint[w] < 0) begin
				mode[w] = ddpid_pkg::MODE_NEG;
			end else begin
				mode[w] = ddpid_pkg::MODE_STOP;
				duty[w] = 0;
			end
		endfunction

		function void tick_wheel(int w, longint meas);
			longint e0;
			longint sum;
			longint d;
			e0 = sat18(setpoint[w] - meas);
			sum = gain[w][0] * e0 + gain[w][1] * err[w][0] + gain[w][2] * err[w][1];
			d = duty[w] + sum / longint'(1 << ddpid_pkg::FRAC_SHIFT);
			err[w][1] = err[w][0];
			err[w][0] = e0;
			case (mode[w])
				ddpid_pkg::MODE_POS: begin
					if (d > PWM_LIMIT) d = PWM_LIMIT;
					if (d < 0) d = 0;
				end
				ddpid_pkg::MODE_NEG: begin
					if (d > 0) d = 0;
					if (d < -PWM_LIMIT) d = -PWM_LIMIT;
				end
				default: d = 0;
			endcase
			duty[w] = d;
		endfunction

		function logic [BRIDGE_W-1:0] bridge_of(int w);
			case (mode[w])
				ddpid_pkg::MODE_POS: return ddpid_pkg::BRIDGE_POS;
				ddpid_pkg::MODE_NEG: return ddpid_pkg::BRIDGE_NEG;
				default:             return ddpid_pkg::BRIDGE_BRAKE;
			endcase
		endfunction

		function void note_item(logic op, logic signed [SPEED_W-1:0] lin,
				logic signed [SPEED_W-1:0] ang, logic signed [SPEED_W-1:0] mr,
				logic signed [SPEED_W-1:0] ml);
			longint half;
			drive_out_t o;
			if (op == OP_CMD) begin
				half = (longint'(ang) * base) / 512;
				set_wheel(WHEEL_R, longint'(lin) + half);
				set_wheel(WHEEL_L, longint'(lin) - half);
			end else begin
				tick_wheel(WHEEL_R, longint'(mr));
				tick_wheel(WHEEL_L, longint'(ml));
			end
			o.pwm_r = duty[WHEEL_R][PWM_W-1:0];
			o.pwm_l = duty[WHEEL_L][PWM_W-1:0];
			o.br_r = bridge_of(WHEEL_R);
			o.br_l = bridge_of(WHEEL_L);
			pending_duty.push_back(o);
		endfunction

		function void cmp(string name, int e, int a);
			if (e != a) begin
				$error("%s expected %0d got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(logic [PWM_W-1:0] pr, logic [PWM_W-1:0] pl,
				logic [BRIDGE_W-1:0] br, logic [BRIDGE_W-1:0] bl);
			drive_out_t o;
			if (pending_duty.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			o = pending_duty.pop_front();
			cmp("pwm_right", $signed(o.pwm_r), $signed(pr));
			cmp("pwm_left", $signed(o.pwm_l), $signed(pl));
			cmp("bridge_right", o.br_r, br);
			cmp("bridge_left", o.br_l, bl);
		endfunction

		function int pending();
			return pending_duty.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit idle_on;
	int unsigned cycles = 0;
	longint aim [2];
	duty_checker sb = new();

	ddpid_item_if item_ch ();
	ddpid_result_if result_ch ();

	diff_drive_incremental_pid u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stalls
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= !(idle_on && $urandom_range(0, 99) < 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (item_ch.valid && item_ch.ready)
				sb.note_item(item_ch.op, item_ch.lin_speed, item_ch.ang_speed,
					item_ch.meas_right, item_ch.meas_left);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.pwm_right, result_ch.pwm_left,
					result_ch.bridge_right, result_ch.bridge_left);
		end
	end

	task automatic send_item(logic op, logic [SPEED_W-1:0] lin, logic [SPEED_W-1:0] ang,
			logic [SPEED_W-1:0] mr, logic [SPEED_W-1:0] ml);
		if (idle_on && $urandom_range(0, 99) < 9) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.lin_speed <= lin;
		item_ch.ang_speed <= ang;
		item_ch.meas_right <= mr;
		item_ch.meas_left <= ml;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic send_cmd(logic [SPEED_W-1:0] lin, logic [SPEED_W-1:0] ang);
		send_item(OP_CMD, lin, ang, SPEED_W'($urandom), SPEED_W'($urandom));
	endtask

	task automatic send_tick(logic [SPEED_W-1:0] mr, logic [SPEED_W-1:0] ml);
		send_item(OP_TICK, SPEED_W'($urandom), SPEED_W'($urandom), mr, ml);
	endtask

	// wait until every result is back and the pipe is empty
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic program_regs(logic [CFG_DATA_W-1:0] g [6], logic [WB_W-1:0] wb,
			bit touch_unused);
		write_cfg(ddpid_pkg::REG_GAIN0_RIGHT, g[0]);
		write_cfg(ddpid_pkg::REG_GAIN1_RIGHT, g[1]);
		write_cfg(ddpid_pkg::REG_GAIN2_RIGHT, g[2]);
		write_cfg(ddpid_pkg::REG_GAIN0_LEFT, g[3]);
		write_cfg(ddpid_pkg::REG_GAIN1_LEFT, g[4]);
		write_cfg(ddpid_pkg::REG_GAIN2_LEFT, g[5]);
		write_cfg(ddpid_pkg::REG_WHEEL_BASE, CFG_DATA_W'(wb));
		if (touch_unused) write_cfg(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_gain(int kind);
		int unsigned m;
		m = $urandom_range(0, 1 << 18);
		case (kind)
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom;
			default: return $urandom_range(0, 1) ? -m : m;
		endcase
	endfunction

	function automatic logic [SPEED_W-1:0] to_speed(longint v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return v[SPEED_W-1:0];
	endfunction

	task automatic random_cmd();
		int sel;
		logic [SPEED_W-1:0] lin;
		logic [SPEED_W-1:0] ang;
		longint half;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			lin = SPEED_W'($urandom_range(0, 4096) - 2048);
			ang = SPEED_W'($urandom_range(0, 4096) - 2048);
		end else if (sel < 85) begin
			lin = SPEED_W'($urandom);
			ang = SPEED_W'($urandom);
		end else if (sel < 90) begin
			lin = '0;
			ang = '0;
		end else begin
			// one wheel lands exactly on zero
			ang = SPEED_W'($urandom_range(0, 2000) - 1000);
			half = (longint'($signed(ang)) * sb.base) / 512;
			lin = to_speed($urandom_range(0, 1) ? half : -half);
		end
		half = (longint'($signed(ang)) * sb.base) / 512;
		aim[WHEEL_R] = longint'($signed(lin)) + half;
		aim[WHEEL_L] = longint'($signed(lin)) - half;
		send_cmd(lin, ang);
	endtask

	task automatic random_tick();
		logic [SPEED_W-1:0] m [2];
		foreach (m[w]) begin
			if ($urandom_range(0, 99) < 60)
				m[w] = to_speed(aim[w] + longint'($urandom_range(0, 600)) - 300);
			else
				m[w] = SPEED_W'($urandom);
		end
		send_tick(m[WHEEL_R], m[WHEEL_L]);
	endtask

	task automatic run_random(int n);
		repeat (n) begin
			if ($urandom_range(0, 99) < 15) random_cmd();
			else random_tick();
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] g [6];
		logic [WB_W-1:0] wb;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_CMD;
		item_ch.lin_speed = '0;
		item_ch.ang_speed = '0;
		item_ch.meas_right = '0;
		item_ch.meas_left = '0;
		idle_on = 1'b1;
		aim[WHEEL_R] = 0;
		aim[WHEEL_L] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: stop mode, zero gains and base
		send_tick(16'h7FFF, 16'h8000);
		send_cmd(16'h0100, 16'h7FFF);
		send_tick(16'h0000, 16'h0000);
		drain();

		// extreme gains and base: saturation everywhere
		g = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
		program_regs(g, 16'hFFFF, 1'b1);
		send_cmd(16'h7FFF, 16'h7FFF);
		send_tick(16'h8000, 16'h7FFF);
		send_tick(16'h7FFF, 16'h8000);
		send_cmd(16'h8000, 16'h8000);
		send_tick(16'h0000, 16'h0000);
		send_tick(16'h8000, 16'h8000);
		send_cmd(16'h0000, 16'h0000);
		send_tick(16'h1234, 16'hEDCB);
		send_cmd(16'hFFFF, 16'h0001);
		send_cmd(16'h0000, 16'hFFFF);
		send_cmd(16'h007F, 16'h0001);
		send_tick(16'h0000, 16'h0000);
		drain();

		// moderate gains, odd values for truncation toward zero
		g = '{32'h0010_0000, -32'sh0008_0003, 32'h0002_0005,
			-32'sh000F_FFFF, 32'h0008_0000, -32'sh0004_0000};
		program_regs(g, 16'h0100, 1'b0);
		send_cmd(16'h0200, 16'hFF00);
		send_tick(16'h0000, 16'h0000);
		send_tick(16'h0064, 16'h02BC);
		send_cmd(16'd300, 16'd40);
		send_tick(16'd250, 16'd350);
		send_tick(16'hFFFB, 16'hFFFB);
		send_cmd(-16'sd400, 16'd100);
		send_tick(16'h0000, 16'h0000);
		send_tick(-16'sd600, -16'sd600);
		send_tick(-16'sd300, -16'sd500);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			foreach (g[k]) begin
				if (p == 1) g[k] = pick_gain($urandom_range(1, 2));
				else if (p == 5 && k >= 3) g[k] = pick_gain(0);
				else if ($urandom_range(0, 99) < 10) g[k] = pick_gain($urandom_range(0, 3));
				else g[k] = pick_gain(4);
			end
			case (p)
				1: wb = 16'hFFFF;
				5: wb = '0;
				default: wb = WB_W'($urandom_range(0, 99) < 20 ? $urandom : $urandom_range(0, 1024));
			endcase
			// one phase with no idling on either side
			idle_on = (p != 3);
			program_regs(g, wb, p % 3 == 0);
			run_random(PHASE_ITEMS);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
